// ===== hw/rtl/dshot_pkg.sv =====
// ----------------------------------------------------------------------------
// DShot transmitter package
// Shared widths, codes, transaction payload types and the frame builder.
// ----------------------------------------------------------------------------
package dshot_pkg;

    // Defaults for the top-level parameters
    localparam int MOTOR_COUNT_DEF = 4;
    localparam int COUNT_WIDTH_DEF = 12;

    // Fixed field widths
    localparam int REG_W       = 12;
    localparam int CFG_IDX_W   = 2;
    localparam int OPCODE_W    = 2;
    localparam int MOTOR_IDX_W = 2;
    localparam int THROTTLE_W  = 11;
    localparam int LINE_W      = 4;
    localparam int FRAME_W     = 16;
    localparam int BODY_W      = THROTTLE_W + 1;
    localparam int CSUM_W      = 4;
    localparam int BIT_NUM_W   = 4;

    // Index of the last bit of a frame
    localparam logic [BIT_NUM_W-1:0] LAST_BIT = BIT_NUM_W'(FRAME_W - 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH_TICKS  = 2'd2;

    // Register reset values
    localparam logic [REG_W-1:0] BIT_PERIOD_RST      = 12'd139;
    localparam logic [REG_W-1:0] ZERO_HIGH_TICKS_RST = 12'd41;
    localparam logic [REG_W-1:0] ONE_HIGH_TICKS_RST  = 12'd83;

    // Command opcodes
    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK = 2'd0,
        OP_LOAD = 2'd1,
        OP_FIRE = 2'd2
    } t_opcode;

    // Command transaction payload
    typedef struct packed {
        t_opcode                opcode;
        logic [MOTOR_IDX_W-1:0] motor_index;
        logic [THROTTLE_W-1:0]  throttle_value;
        logic                   telemetry_request;
    } t_command;

    // Result transaction payload
    typedef struct packed {
        logic [LINE_W-1:0] motor_lines;
        logic              busy_res;
        logic              frame_done;
        logic              fire_skipped;
    } t_result;

    // 11-bit value, telemetry bit, then XOR of the three body nibbles
    function automatic logic [FRAME_W-1:0] build_frame(
        input logic [THROTTLE_W-1:0] value,
        input logic                  tele
    );
        logic [BODY_W-1:0] body;
        logic [CSUM_W-1:0] csum;
        body = {value, tele};
        csum = body[3:0] ^ body[7:4] ^ body[11:8];
        return {body, csum};
    endfunction

endpackage

// ===== hw/rtl/dshot_if.sv =====
// ----------------------------------------------------------------------------
// DShot stream interface
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface dshot_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/dshot_skid.sv =====
// ----------------------------------------------------------------------------
// DShot result skid buffer
// Output register plus one skid entry, so upstream keeps going for one
// transaction after the receiver stalls.
// ----------------------------------------------------------------------------
module dshot_skid #(
    parameter type T = logic
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  T       i_data,
    dshot_if.source o_res
);

    logic r_out_valid, n_out_valid;
    logic r_skid_valid, n_skid_valid;
    T     r_out_data, n_out_data;
    T     r_skid_data, n_skid_data;
    logic in_accept;

    assign o_ready   = !r_skid_valid;
    assign in_accept = i_valid && !r_skid_valid;

    // Output slot refills from the skid entry first, then from the input
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;
        if (!r_out_valid || o_res.ready) begin
            n_out_valid  = r_skid_valid || in_accept;
            n_out_data   = r_skid_valid ? r_skid_data : i_data;
            n_skid_valid = 1'b0;
        end else if (in_accept) begin
            n_skid_valid = 1'b1;
            n_skid_data  = i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out_data;

    // Skid entry only fills behind a stalled output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without output entry");

endmodule

// ===== hw/rtl/dshot_frame_transmitter.sv =====
// ----------------------------------------------------------------------------
// DShot frame transmitter
// Multi-motor DShot frame builder and bit-timing generator.
// ----------------------------------------------------------------------------
// Usage:
//   i_cmd carries command transactions: tick (one timer clock), load (build
//   and stage one motor's 16-bit frame) and fire (copy all staged frames into
//   the shift registers and start sending). o_res returns one result
//   transaction per command: line levels, busy, frame done and fire skipped.
//   Configuration (bit period and the two high-time thresholds) is written
//   through i_cfg_we / i_cfg_idx / i_cfg_data while the block is idle.
// Timing:
//   Each command is applied in the cycle it is accepted; its result is
//   registered in the output buffer before it appears on o_res. One command
//   per cycle is sustained while the output buffer has room for results.
// Reset:
//   Synchronous, active low. Staged and shift frames clear, lines go low,
//   the timer stops and the registers return to 139 / 41 / 83.
// Stall:
//   A two-entry output buffer holds results; with both entries full i_cmd
//   ready drops until the receiver takes a result.
// ----------------------------------------------------------------------------
module dshot_frame_transmitter #(
    parameter int MOTOR_COUNT = dshot_pkg::MOTOR_COUNT_DEF,
    parameter int COUNT_WIDTH = dshot_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [dshot_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [dshot_pkg::REG_W-1:0]     i_cfg_data,
    dshot_if.sink                          i_cmd,
    dshot_if.source                        o_res
);

    localparam int CMP_W = (COUNT_WIDTH > dshot_pkg::REG_W) ? COUNT_WIDTH : dshot_pkg::REG_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // Configuration registers
    logic [dshot_pkg::REG_W-1:0] r_bit_period;
    logic [dshot_pkg::REG_W-1:0] r_zero_high;
    logic [dshot_pkg::REG_W-1:0] r_one_high;

    // Transmitter state
    logic [dshot_pkg::FRAME_W-1:0]   r_staged [MOTOR_COUNT];
    logic [dshot_pkg::FRAME_W-1:0]   n_staged [MOTOR_COUNT];
    logic [dshot_pkg::FRAME_W-1:0]   r_shift  [MOTOR_COUNT];
    logic [dshot_pkg::FRAME_W-1:0]   n_shift  [MOTOR_COUNT];
    logic                            r_sending, n_sending;
    logic [dshot_pkg::BIT_NUM_W-1:0] r_bit_num, n_bit_num;
    logic [COUNT_WIDTH-1:0]          r_tick, n_tick;
    logic [MOTOR_COUNT-1:0]          r_lines, n_lines;

    logic               cmd_ready;
    logic               cmd_accept;
    logic               bit_end;
    logic               frame_done;
    logic               fire_skipped;
    logic [CMP_W-1:0]   tick_ext;
    dshot_pkg::t_result res;

    assign i_cmd.ready = cmd_ready;
    assign cmd_accept  = i_cmd.valid && cmd_ready;
    assign tick_ext    = CMP_W'(r_tick);
    assign bit_end     = (tick_ext >= CMP_W'(r_bit_period)) || (r_tick == COUNT_MAX);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_period <= dshot_pkg::BIT_PERIOD_RST;
            r_zero_high  <= dshot_pkg::ZERO_HIGH_TICKS_RST;
            r_one_high   <= dshot_pkg::ONE_HIGH_TICKS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dshot_pkg::CFG_BIT_PERIOD:      r_bit_period <= i_cfg_data;
                dshot_pkg::CFG_ZERO_HIGH_TICKS: r_zero_high  <= i_cfg_data;
                dshot_pkg::CFG_ONE_HIGH_TICKS:  r_one_high   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Command decode and next state
    always_comb begin
        n_staged     = r_staged;
        n_shift      = r_shift;
        n_sending    = r_sending;
        n_bit_num    = r_bit_num;
        n_tick       = r_tick;
        n_lines      = r_lines;
        frame_done   = 1'b0;
        fire_skipped = 1'b0;
        if (cmd_accept) begin
            case (i_cmd.data.opcode)
                dshot_pkg::OP_TICK: begin
                    if (r_sending) begin
                        // line levels for the current bit
                        if (r_tick == '0) begin
                            n_lines = '1;
                        end
                        if (tick_ext == CMP_W'(r_zero_high)) begin
                            for (int m = 0; m < MOTOR_COUNT; m++) begin
                                n_lines[m] = n_lines[m] & r_shift[m][dshot_pkg::FRAME_W-1];
                            end
                        end
                        if (tick_ext == CMP_W'(r_one_high)) begin
                            n_lines = '0;
                        end
                        // bit timer
                        if (bit_end) begin
                            n_tick = '0;
                            for (int m = 0; m < MOTOR_COUNT; m++) begin
                                n_shift[m] = {r_shift[m][dshot_pkg::FRAME_W-2:0], 1'b0};
                            end
                            if (r_bit_num == dshot_pkg::LAST_BIT) begin
                                n_bit_num  = '0;
                                n_sending  = 1'b0;
                                frame_done = 1'b1;
                            end else begin
                                n_bit_num = r_bit_num + 1'b1;
                            end
                        end else begin
                            n_tick = r_tick + 1'b1;
                        end
                    end
                end
                dshot_pkg::OP_LOAD: begin
                    for (int m = 0; m < MOTOR_COUNT; m++) begin
                        if (int'(i_cmd.data.motor_index) == m) begin
                            n_staged[m] = dshot_pkg::build_frame(i_cmd.data.throttle_value,
                                                                 i_cmd.data.telemetry_request);
                        end
                    end
                end
                dshot_pkg::OP_FIRE: begin
                    if (r_sending) begin
                        fire_skipped = 1'b1;
                    end else begin
                        n_shift   = r_staged;
                        n_sending = 1'b1;
                        n_bit_num = '0;
                        n_tick    = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Result fields from the updated state
    always_comb begin
        res = '0;
        for (int b = 0; b < dshot_pkg::LINE_W; b++) begin
            if (b < MOTOR_COUNT) begin
                res.motor_lines[b] = n_lines[b];
            end
        end
        res.busy_res     = n_sending;
        res.frame_done   = frame_done;
        res.fire_skipped = fire_skipped;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int m = 0; m < MOTOR_COUNT; m++) begin
                r_staged[m] <= '0;
                r_shift[m]  <= '0;
            end
            r_sending <= 1'b0;
            r_bit_num <= '0;
            r_tick    <= '0;
            r_lines   <= '0;
        end else begin
            r_staged  <= n_staged;
            r_shift   <= n_shift;
            r_sending <= n_sending;
            r_bit_num <= n_bit_num;
            r_tick    <= n_tick;
            r_lines   <= n_lines;
        end
    end

    // Result buffer
    dshot_skid #(
        .T(dshot_pkg::t_result)
    ) u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cmd_accept),
        .o_ready (cmd_ready),
        .i_data  (res),
        .o_res   (o_res)
    );

    // Frame ends only after the last bit
    a_end_on_last_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_sending) |-> $past(r_bit_num) == dshot_pkg::LAST_BIT)
        else $error("transmission ended before the last bit");

    // Timer and bit counter rest at zero while idle
    a_idle_counters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_sending |-> (r_tick == '0) && (r_bit_num == '0))
        else $error("timer running while idle");

    // State moves only on an accepted transaction
    a_hold_without_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !cmd_accept |=> $stable(r_sending) && $stable(r_tick) && $stable(r_lines))
        else $error("state changed without a command transaction");

endmodule
